// ----- rtl/core/stpwm_pkg.sv -----
// stpwm_pkg: shared constants, types and the quarter-wave sine rom for the
// sine-triangle pwm bridge and rl load slope pipeline
// depends on nothing
package stpwm_pkg;

    localparam int PHASE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_IDX_BITS    = SINE_ADDR_BITS + 2;

    localparam int TIME_W    = 48;
    localparam int CURRENT_W = 32;
    localparam int VOLT_W    = 24;
    localparam int SLOPE_W   = 48;
    localparam int PIPE_DEPTH = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 36;

    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_HZ       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULATING_FREQ  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOD_DEPTH        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DC_LINK_VOLTAGE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_OHMS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_INDUCTANCE   = 3'd5;

    typedef struct packed {
        logic [35:0] carrier_hz;
        logic [27:0] modulating_freq;
        logic [15:0] mod_depth;
        logic [23:0] dc_link_voltage;
        logic [23:0] load_ohms;
        logic [31:0] inv_inductance;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        carrier_hz:       36'd655360000,
        modulating_freq:  28'd3276800,
        mod_depth:        16'd26214,
        dc_link_voltage:  24'd0,
        load_ohms:        24'd0,
        inv_inductance:   32'd0
    };

    typedef struct packed {
        logic [PHASE_BITS-1:0]       carrier_phase;
        logic [PHASE_BITS-1:0]       mod_phase;
        logic signed [CURRENT_W-1:0] load_current;
    } t_phase;

    // triangle compare is done at a quarter of the 2^32 scale
    localparam logic signed [33:0] TRI_ONE   = 34'sh040000000;
    localparam logic signed [33:0] TRI_THREE = 34'sh0C0000000;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;

    typedef logic [7:0] t_taylor_div [1:6];
    localparam t_taylor_div TAYLOR_DIV = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

    typedef logic [15:0] t_sine_rom [SINE_TABLE_DEPTH+1];

    // sin over a quarter turn in q1.15, taylor series in q2.30 to x^13
    function automatic t_sine_rom sine_rom_build();
        t_sine_rom        rom;
        logic [63:0]      x;
        logic [63:0]      x2;
        logic [63:0]      term;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (64'(k) * PIHALF_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > Q30_ONE) begin
                sum = Q30_ONE;
            end
            rom[k] = 16'((sum + 64'sd16384) >>> 15);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_rom_build();

endpackage

// ----- rtl/core/sine_triangle_pwm_rl_derivative.sv -----
// sine_triangle_pwm_rl_derivative: sine-triangle pwm bridge with an rl load,
// one time sample in, one result out. The block takes one transfer per cycle
// unless the output stalls, and passes each result through two stages of
// phase multiply and sum, three for the sine rom read, index scaling and
// triangle compare, and a slope path whose 57 by 32 bit product is split into
// two partial products across a stage ahead of the rounding add and the output
// registers. A stall at the output freezes the whole pipeline, so input ready
// follows output ready while the output register is full. Configuration
// writes are taken in any cycle, one per transfer, and act at once; writes to
// an index past the last register are dropped. Uses stpwm_pkg and the
// stpwm_cfg_regs, stpwm_phase, stpwm_sine and stpwm_slope modules.
module sine_triangle_pwm_rl_derivative (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [stpwm_pkg::TIME_W-1:0]            i_time_stamp,
    input  logic signed [stpwm_pkg::CURRENT_W-1:0]  i_load_current,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_switch_high,
    output logic signed [stpwm_pkg::VOLT_W-1:0]     o_bridge_voltage,
    output logic signed [stpwm_pkg::SLOPE_W-1:0]    o_current_slope,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [stpwm_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [stpwm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import stpwm_pkg::*;

    t_cfg   w_cfg;
    t_phase w_phase;
    logic   w_hi;
    logic   w_adv;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    assign w_adv      = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready = w_adv;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_comb begin
        n_vld = r_vld;
        if (w_adv) begin
            n_vld = {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    stpwm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    stpwm_phase u_phase (
        .i_clk          (i_clk),
        .i_adv          (w_adv),
        .i_time_stamp   (i_time_stamp),
        .i_load_current (i_load_current),
        .i_cfg          (w_cfg),
        .o_phase        (w_phase)
    );

    stpwm_sine u_sine (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_phase (w_phase),
        .i_cfg   (w_cfg),
        .o_hi    (w_hi)
    );

    stpwm_slope u_slope (
        .i_clk            (i_clk),
        .i_adv            (w_adv),
        .i_load_current   (w_phase.load_current),
        .i_hi             (w_hi),
        .i_cfg            (w_cfg),
        .o_switch_high    (o_switch_high),
        .o_bridge_voltage (o_bridge_voltage),
        .o_current_slope  (o_current_slope)
    );

    a_stall_holds_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_switch_matches_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_bridge_voltage != '0) |-> o_switch_high == !o_bridge_voltage[VOLT_W-1])
        else $error("switch state disagrees with bridge voltage sign");

endmodule

// ----- rtl/core/stpwm_cfg_regs.sv -----
// stpwm_cfg_regs: configuration register file, one write per transfer
// depends on stpwm_pkg
module stpwm_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stpwm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [stpwm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output stpwm_pkg::t_cfg                    o_cfg
);
    import stpwm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CARRIER_HZ:       n_cfg.carrier_hz       = i_cfg_data[35:0];
                CFG_MODULATING_FREQ:  n_cfg.modulating_freq  = i_cfg_data[27:0];
                CFG_MOD_DEPTH:        n_cfg.mod_depth        = i_cfg_data[15:0];
                CFG_DC_LINK_VOLTAGE:  n_cfg.dc_link_voltage  = i_cfg_data[23:0];
                CFG_LOAD_OHMS:        n_cfg.load_ohms        = i_cfg_data[23:0];
                CFG_INV_INDUCTANCE:   n_cfg.inv_inductance   = i_cfg_data[31:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ----- rtl/core/stpwm_phase.sv -----
// stpwm_phase: two stages forming carrier and reference phases from the
// time stamp, low 48 bits of freq*time kept; depends on stpwm_pkg
module stpwm_phase (
    input  logic                                    i_clk,
    input  logic                                    i_adv,
    input  logic [stpwm_pkg::TIME_W-1:0]            i_time_stamp,
    input  logic signed [stpwm_pkg::CURRENT_W-1:0]  i_load_current,
    input  stpwm_pkg::t_cfg                         i_cfg,
    output stpwm_pkg::t_phase                       o_phase
);
    import stpwm_pkg::*;

    logic [23:0] w_tlo;
    logic [23:0] w_thi;
    logic [59:0] w_c_lo;
    logic [47:0] w_c_hi;
    logic [51:0] w_m_lo;
    logic [47:0] w_m_hi;
    logic [47:0] w_c_sum;
    logic [47:0] w_m_sum;

    logic [47:0]                 r_c_lo;
    logic [23:0]                 r_c_hi;
    logic [47:0]                 r_m_lo;
    logic [23:0]                 r_m_hi;
    logic signed [CURRENT_W-1:0] r_cur_a;
    t_phase                      r_phase;

    assign w_tlo  = i_time_stamp[23:0];
    assign w_thi  = i_time_stamp[47:24];
    assign w_c_lo = i_cfg.carrier_hz * w_tlo;
    assign w_c_hi = i_cfg.carrier_hz[23:0] * w_thi;
    assign w_m_lo = i_cfg.modulating_freq * w_tlo;
    assign w_m_hi = i_cfg.modulating_freq[23:0] * w_thi;

    assign w_c_sum = r_c_lo + {r_c_hi, 24'd0};
    assign w_m_sum = r_m_lo + {r_m_hi, 24'd0};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_lo  <= w_c_lo[47:0];
            r_c_hi  <= w_c_hi[23:0];
            r_m_lo  <= w_m_lo[47:0];
            r_m_hi  <= w_m_hi[23:0];
            r_cur_a <= i_load_current;
            r_phase.carrier_phase <= w_c_sum[47 -: PHASE_BITS];
            r_phase.mod_phase     <= w_m_sum[47 -: PHASE_BITS];
            r_phase.load_current  <= r_cur_a;
        end
    end

    assign o_phase = r_phase;

endmodule

// ----- rtl/core/stpwm_sine.sv -----
// stpwm_sine: rom lookup, modulation index scaling and triangle compare over
// three stages; depends on stpwm_pkg
module stpwm_sine (
    input  logic              i_clk,
    input  logic              i_adv,
    input  stpwm_pkg::t_phase i_phase,
    input  stpwm_pkg::t_cfg   i_cfg,
    output logic              o_hi
);
    import stpwm_pkg::*;

    logic [PHASE_BITS+SINE_IDX_BITS-1:0] w_scaled;
    logic [SINE_IDX_BITS-1:0]            w_idx;
    logic [1:0]                          w_quad;
    logic [SINE_ADDR_BITS:0]             w_k;
    logic [SINE_ADDR_BITS:0]             w_addr;
    logic [31:0]                         w_p32;
    logic signed [33:0]                  w_p32s;
    logic signed [33:0]                  w_tri;
    logic signed [16:0]                  w_sine;

    logic [15:0]        r_rom;
    logic               r_neg_c;
    logic signed [33:0] r_tri_c;
    logic signed [33:0] r_tri_d;
    logic signed [33:0] r_prod_d;
    logic               r_hi;

    assign w_scaled = {i_phase.mod_phase, SINE_IDX_BITS'(0)};
    assign w_idx    = w_scaled[PHASE_BITS+SINE_IDX_BITS-1 -: SINE_IDX_BITS];
    assign w_quad   = w_idx[SINE_IDX_BITS-1 -: 2];
    assign w_k      = {1'b0, w_idx[SINE_ADDR_BITS-1:0]};
    assign w_addr   = w_quad[0] ? ((SINE_ADDR_BITS+1)'(SINE_TABLE_DEPTH) - w_k) : w_k;

    assign w_p32  = 32'(i_phase.carrier_phase) << (32 - PHASE_BITS);
    assign w_p32s = $signed({2'b00, w_p32});
    assign w_tri  = w_p32[31] ? (TRI_THREE - w_p32s) : (w_p32s - TRI_ONE);

    assign w_sine = r_neg_c ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rom    <= SINE_ROM[w_addr];
            r_neg_c  <= w_quad[1];
            r_tri_c  <= w_tri;
            r_prod_d <= $signed({1'b0, i_cfg.mod_depth}) * w_sine;
            r_tri_d  <= r_tri_c;
            r_hi     <= (r_prod_d >= r_tri_d);
        end
    end

    assign o_hi = r_hi;

endmodule

// ----- rtl/core/stpwm_slope.sv -----
// stpwm_slope: bridge voltage and rounded, saturated (v - r*i)/l over six
// stages, ending in the output registers; depends on stpwm_pkg
module stpwm_slope (
    input  logic                                    i_clk,
    input  logic                                    i_adv,
    input  logic signed [stpwm_pkg::CURRENT_W-1:0]  i_load_current,
    input  logic                                    i_hi,
    input  stpwm_pkg::t_cfg                         i_cfg,
    output logic                                    o_switch_high,
    output logic signed [stpwm_pkg::VOLT_W-1:0]     o_bridge_voltage,
    output logic signed [stpwm_pkg::SLOPE_W-1:0]    o_current_slope
);
    import stpwm_pkg::*;

    logic signed [VOLT_W-1:0] w_half;
    logic signed [57:0]       w_vpos;
    logic signed [57:0]       w_dp;
    logic signed [57:0]       w_dn;
    logic signed [57:0]       w_d;
    logic signed [57:0]       w_d_neg;
    logic [89:0]              w_total;
    logic [51:0]              w_q;
    logic                     w_sat;
    logic signed [SLOPE_W-1:0] w_qs;
    logic signed [SLOPE_W-1:0] w_slope;

    logic signed [56:0]        r_rc_c;
    logic signed [56:0]        r_rc_d;
    logic signed [57:0]        r_dp;
    logic signed [57:0]        r_dn;
    logic [56:0]               r_mag;
    logic                      r_neg_f;
    logic                      r_hi_f;
    logic signed [VOLT_W-1:0]  r_v_f;
    logic [63:0]               r_lprod;
    logic [56:0]               r_hprod;
    logic                      r_neg_g;
    logic                      r_hi_g;
    logic signed [VOLT_W-1:0]  r_v_g;
    logic                      r_hi_h;
    logic signed [VOLT_W-1:0]  r_v_h;
    logic signed [SLOPE_W-1:0] r_slope;

    assign w_half = $signed({1'b0, i_cfg.dc_link_voltage[23:1]});
    assign w_vpos = $signed({11'd0, i_cfg.dc_link_voltage[23:1], 24'd0});
    assign w_dp   = w_vpos - r_rc_d;
    assign w_dn   = -w_vpos - r_rc_d;

    assign w_d     = i_hi ? r_dp : r_dn;
    assign w_d_neg = -w_d;

    // ties round away from zero on the magnitude
    assign w_total = {r_hprod, 32'd0} + {26'd0, r_lprod} + (90'd1 << 37);
    assign w_q     = w_total[89:38];
    assign w_sat   = |w_q[51:47];
    assign w_qs    = $signed({1'b0, w_q[46:0]});

    always_comb begin
        if (r_neg_g) begin
            w_slope = w_sat ? SLOPE_MIN : -w_qs;
        end else begin
            w_slope = w_sat ? SLOPE_MAX : w_qs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rc_c  <= $signed({1'b0, i_cfg.load_ohms}) * i_load_current;
            r_rc_d  <= r_rc_c;
            r_dp    <= w_dp;
            r_dn    <= w_dn;
            r_neg_f <= w_d[57];
            r_mag   <= w_d[57] ? w_d_neg[56:0] : w_d[56:0];
            r_hi_f  <= i_hi;
            r_v_f   <= i_hi ? w_half : -w_half;
            r_lprod <= r_mag[31:0] * i_cfg.inv_inductance;
            r_hprod <= r_mag[56:32] * i_cfg.inv_inductance;
            r_neg_g <= r_neg_f;
            r_hi_g  <= r_hi_f;
            r_v_g   <= r_v_f;
            r_slope <= w_slope;
            r_hi_h  <= r_hi_g;
            r_v_h   <= r_v_g;
        end
    end

    assign o_switch_high    = r_hi_h;
    assign o_bridge_voltage = r_v_h;
    assign o_current_slope  = r_slope;

endmodule
